>>> rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator package
// Token and status codes, field widths and sequencer states shared by the
// channel interfaces and the core.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int CMD_W    = 3;
  localparam int DIGIT_W  = 4;
  localparam int STATUS_W = 3;

  // token kinds
  localparam logic [CMD_W-1:0] CMD_DIGIT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADTOK   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MAGB,
    S_LOOP,
    S_FIX,
    S_EMIT
  } state_t;

endpackage

>>> rtl/rpn_in_if.sv
// ----------------------------------------------------------------------------
// RPN token channel
// Valid/ready channel carrying one token request per transfer.
// ----------------------------------------------------------------------------
interface rpn_in_if import rpn_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [DIGIT_W-1:0] digit;
  logic               end_of_expr;

  modport source (output valid, output cmd, output digit, output end_of_expr,
                  input ready);
  modport sink   (input valid, input cmd, input digit, input end_of_expr,
                  output ready);

endinterface

>>> rtl/rpn_out_if.sv
// ----------------------------------------------------------------------------
// RPN result channel
// Valid/ready channel carrying one result request per transfer.
// ----------------------------------------------------------------------------
interface rpn_out_if import rpn_pkg::*; #(
  parameter int VALUE_WIDTH = 48
) ();

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);

endinterface

>>> rtl/rpn_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator core
// Evaluates a token stream in reverse Polish notation on signed fixed-point
// operands and returns one value or error status per expression.
// ----------------------------------------------------------------------------
// Tokens are taken one at a time: the core is ready only when its sequencer is
// idle. A digit, or any token while skipping after an error, is handled in the
// idle state. Add and subtract read the stack, then make one pass through the
// shared adder. Multiply and divide read the stack, then run bit-serial
// through the single VALUE_WIDTH+1 bit adder, which also forms the operand
// magnitudes and the final negation. A token that ends an expression or
// raises an error then passes through the emit state to load the result
// register; that register lets the next token in while the result waits to
// be taken. The top of stack lives in a register, the entries below it in a
// one-write, one-read memory with registered read data.
module rpn_stack_evaluator_core import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = 16,
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  localparam int W      = VALUE_WIDTH;
  localparam int AW     = VALUE_WIDTH + 1;
  localparam int LO_W   = VALUE_WIDTH + FRACTION_BITS;
  localparam int MAG_W  = 2 * VALUE_WIDTH + FRACTION_BITS;
  localparam int DIG_W  = VALUE_WIDTH + FRACTION_BITS + DIGIT_W;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int STEP_W = $clog2(VALUE_WIDTH + FRACTION_BITS + 1);

  localparam logic [W-1:0] V_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] V_MIN = {1'b1, {(W-1){1'b0}}};

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                skip_r, skip_nxt;
  logic                out_valid_r, out_valid_nxt;

  // datapath
  logic [W-1:0]        tos_r, tos_nxt;
  logic [CMD_W-1:0]    op_r, op_nxt;
  logic                end_r, end_nxt;
  logic                neg_r, neg_nxt;
  logic [W-1:0]        hi_r, hi_nxt;
  logic [LO_W-1:0]     lo_r, lo_nxt;
  logic [W-1:0]        opb_r, opb_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [STATUS_W-1:0] pend_status_r, pend_status_nxt;
  logic [W-1:0]        out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // stack memory below the top entry
  logic [W-1:0]        stack_mem [STACK_DEPTH];
  logic [W-1:0]        rd_data_r;
  logic                mem_we;
  logic                rd_en;
  logic [IDX_W-1:0]    push_idx;
  logic [IDX_W-1:0]    rd_idx;

  // shared adder
  logic [AW-1:0]       add_a;
  logic [AW-1:0]       add_b;
  logic                add_sub;
  logic [AW-1:0]       add_sum;

  logic                in_acc;
  logic                err;
  logic [STATUS_W-1:0] err_status;
  logic                op_done;
  logic [W-1:0]        op_res;
  logic [AW-1:0]       mul_t;
  logic                div_ge;
  logic [DIG_W-1:0]    dig_ext;
  logic [W-1:0]        dig_val;
  logic [MAG_W-1:0]    mag_ext;
  logic                mag_sat;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  assign push_idx = IDX_W'(count_r - CNT_W'(1));
  assign rd_idx   = IDX_W'(count_r - CNT_W'(2));

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

  // pushed digit, clamped when it does not fit the format
  assign dig_ext = DIG_W'(in_ch.digit) << FRACTION_BITS;
  assign dig_val = (|dig_ext[DIG_W-1:W-1]) ? V_MAX : dig_ext[W-1:0];

  // unsigned magnitude of the multiply or divide result, before saturation
  assign mag_ext = (op_r == CMD_MUL) ?
                   (MAG_W'({hi_r, lo_r[W-1:0]}) >> FRACTION_BITS) : MAG_W'(lo_r);
  assign mag_sat = |mag_ext[MAG_W-1:W-1];

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    skip_nxt        = skip_r;
    tos_nxt         = tos_r;
    op_nxt          = op_r;
    end_nxt         = end_r;
    neg_nxt         = neg_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    opb_nxt         = opb_r;
    step_nxt        = step_r;
    pend_status_nxt = pend_status_r;
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    add_a           = '0;
    add_b           = '0;
    add_sub         = 1'b0;
    err             = 1'b0;
    err_status      = ST_OK;
    op_done         = 1'b0;
    op_res          = '0;
    mul_t           = '0;
    div_ge          = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (skip_r) begin
            // drop tokens up to the end mark
            if (in_ch.end_of_expr) begin
              skip_nxt  = 1'b0;
              count_nxt = '0;
            end
          end else if (in_ch.cmd == CMD_DIGIT) begin
            if (in_ch.digit > DIGIT_MAX) begin
              err        = 1'b1;
              err_status = ST_BADTOK;
            end else if (count_r == CNT_W'(STACK_DEPTH)) begin
              err        = 1'b1;
              err_status = ST_OVER;
            end else begin
              mem_we    = (count_r != '0);
              tos_nxt   = dig_val;
              count_nxt = count_r + CNT_W'(1);
              if (in_ch.end_of_expr) begin
                pend_status_nxt = (count_r == '0) ? ST_OK : ST_LEFTOVER;
                count_nxt       = '0;
                state_nxt       = S_EMIT;
              end
            end
          end else if (in_ch.cmd inside {[CMD_ADD:CMD_DIV]}) begin
            if (count_r < CNT_W'(2)) begin
              err        = 1'b1;
              err_status = ST_UNDER;
            end else if (in_ch.cmd == CMD_DIV && tos_r == '0) begin
              err        = 1'b1;
              err_status = ST_DIVZERO;
            end else begin
              rd_en     = 1'b1;
              op_nxt    = in_ch.cmd;
              end_nxt   = in_ch.end_of_expr;
              state_nxt = S_FETCH;
            end
          end else begin
            err        = 1'b1;
            err_status = ST_BADTOK;
          end

          if (err) begin
            pend_status_nxt = err_status;
            count_nxt       = '0;
            skip_nxt        = !in_ch.end_of_expr;
            state_nxt       = S_EMIT;
          end
        end
      end

      S_FETCH: begin
        if (op_r == CMD_ADD || op_r == CMD_SUB) begin
          add_a   = {rd_data_r[W-1], rd_data_r};
          add_b   = {tos_r[W-1], tos_r};
          add_sub = (op_r == CMD_SUB);
          op_done = 1'b1;
          if (add_sum[W] != add_sum[W-1]) begin
            op_res = add_sum[W] ? V_MIN : V_MAX;
          end else begin
            op_res = add_sum[W-1:0];
          end
        end else begin
          // magnitude of the left operand
          add_b   = {rd_data_r[W-1], rd_data_r};
          add_sub = rd_data_r[W-1];
          neg_nxt = rd_data_r[W-1] ^ tos_r[W-1];
          if (op_r == CMD_MUL) begin
            opb_nxt = add_sum[W-1:0];
          end else begin
            lo_nxt = LO_W'(add_sum[W-1:0]) << FRACTION_BITS;
          end
          state_nxt = S_MAGB;
        end
      end

      S_MAGB: begin
        // magnitude of the right operand
        add_b   = {tos_r[W-1], tos_r};
        add_sub = tos_r[W-1];
        hi_nxt  = '0;
        if (op_r == CMD_MUL) begin
          lo_nxt   = LO_W'(add_sum[W-1:0]);
          step_nxt = STEP_W'(VALUE_WIDTH);
        end else begin
          opb_nxt  = add_sum[W-1:0];
          step_nxt = STEP_W'(VALUE_WIDTH + FRACTION_BITS);
        end
        state_nxt = S_LOOP;
      end

      S_LOOP: begin
        if (op_r == CMD_MUL) begin
          // shift-add, multiplier bits from the bottom
          add_a     = {1'b0, hi_r};
          add_b     = {1'b0, opb_r};
          mul_t     = lo_r[0] ? add_sum : {1'b0, hi_r};
          hi_nxt    = mul_t[W:1];
          lo_nxt    = lo_r >> 1;
          lo_nxt[W-1] = mul_t[0];
        end else begin
          // restoring divide, quotient bits shift in behind the numerator
          add_a   = {hi_r, lo_r[LO_W-1]};
          add_b   = {1'b0, opb_r};
          add_sub = 1'b1;
          div_ge  = !add_sum[W];
          hi_nxt  = div_ge ? add_sum[W-1:0] : {hi_r[W-2:0], lo_r[LO_W-1]};
          lo_nxt  = {lo_r[LO_W-2:0], div_ge};
        end
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = S_FIX;
        end
      end

      S_FIX: begin
        add_b   = {1'b0, mag_ext[W-1:0]};
        add_sub = 1'b1;
        op_done = 1'b1;
        if (mag_sat) begin
          op_res = neg_r ? V_MIN : V_MAX;
        end else begin
          op_res = neg_r ? add_sum[W-1:0] : mag_ext[W-1:0];
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (pend_status_r == ST_OK) ? tos_r : '0;
          out_status_nxt = pend_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // two operands collapse into the new top
    if (op_done) begin
      tos_nxt   = op_res;
      count_nxt = count_r - CNT_W'(1);
      if (end_r) begin
        pend_status_nxt = (count_r == CNT_W'(2)) ? ST_OK : ST_LEFTOVER;
        count_nxt       = '0;
        state_nxt       = S_EMIT;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r         <= tos_nxt;
    op_r          <= op_nxt;
    end_r         <= end_nxt;
    neg_r         <= neg_nxt;
    hi_r          <= hi_nxt;
    lo_r          <= lo_nxt;
    opb_r         <= opb_nxt;
    step_r        <= step_nxt;
    pend_status_r <= pend_status_nxt;
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[push_idx] <= tos_r;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_idx];
    end
  end

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !skip_r && count_r < CNT_W'(2) &&
    (in_ch.cmd == CMD_ADD || in_ch.cmd == CMD_SUB ||
     in_ch.cmd == CMD_MUL || in_ch.cmd == CMD_DIV)
    |=> state_r == S_EMIT && pend_status_r == ST_UNDER)
    else $error("operator on short stack did not report underflow");

  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOP |=> state_r == S_LOOP || state_r == S_FIX)
    else $error("iteration left the loop other than through the fix-up step");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_value_r == '0)
    else $error("error result carries a nonzero value");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN stack evaluator testbench
// Sends token requests through the input channel with random gaps and takes
// results with random stalls. A fixed-point stack model predicts each value
// and status, and every result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import rpn_pkg::*;

  localparam int VW    = 48;
  localparam int FB    = 16;
  localparam int DEPTH = 16;

  localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  // token kinds above divide are all rejected
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = CMD_DIV + CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = '1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [DIGIT_W-1:0] digit;
    logic               eoe;
  } token_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [STATUS_W-1:0]  status;
  } result_t;

  logic clk;
  logic rst_n;

  rpn_in_if                       in_ch();
  rpn_out_if #(.VALUE_WIDTH(VW))  out_ch();

  rpn_stack_evaluator_core #(
    .STACK_DEPTH  (DEPTH),
    .VALUE_WIDTH  (VW),
    .FRACTION_BITS(FB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  token_t  token_q[$];
  result_t results_due[$];
  int      mismatches = 0;

  // evaluator state
  longint  opnds[DEPTH];
  int      depth = 0;
  bit      skipping = 0;

  // handshake bookkeeping for the driver and monitor blocks
  bit      tok_taken = 0;
  bit      res_taken = 0;
  bit      steady = 0;
  int      tok_gap = 0;
  int      res_stall = 0;
  int      taken_cnt = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_DIGIT;
    in_ch.digit = '0;
    in_ch.end_of_expr = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [63:0] mag_of(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp_mag(input logic [127:0] mag, input bit neg);
    if (neg) begin
      if (mag >= 128'(VMAX) + 1) return VMIN;
      return -longint'(mag[63:0]);
    end
    if (mag > 128'(VMAX)) return VMAX;
    return longint'(mag[63:0]);
  endfunction

  function automatic longint clamp_sum(input longint s);
    if (s > VMAX) return VMAX;
    if (s < VMIN) return VMIN;
    return s;
  endfunction

  function automatic void eval_token(input token_t t, output bit emits, output result_t r);
    logic [STATUS_W-1:0] st;
    longint lhs, rhs, acc;
    bit neg;
    st = ST_OK;
    acc = 0;
    emits = 0;
    r.value = '0;
    r.status = ST_OK;
    if (skipping) begin
      if (t.eoe) begin
        skipping = 0;
        depth = 0;
      end
      return;
    end
    if (t.cmd == CMD_DIGIT) begin
      if (t.digit > DIGIT_MAX) st = ST_BADTOK;
      else if (depth >= DEPTH) st = ST_OVER;
      else begin
        opnds[depth] = clamp_sum(longint'(t.digit) <<< FB);
        depth++;
      end
    end else if (t.cmd >= CMD_ADD && t.cmd <= CMD_DIV) begin
      if (depth < 2) st = ST_UNDER;
      else begin
        rhs = opnds[depth-1];
        lhs = opnds[depth-2];
        neg = (lhs < 0) != (rhs < 0);
        case (t.cmd)
          CMD_ADD: acc = clamp_sum(lhs + rhs);
          CMD_SUB: acc = clamp_sum(lhs - rhs);
          CMD_MUL: acc = clamp_mag((128'(mag_of(lhs)) * 128'(mag_of(rhs))) >> FB, neg);
          default: begin
            if (rhs == 0) st = ST_DIVZERO;
            else acc = clamp_mag((128'(mag_of(lhs)) << FB) / 128'(mag_of(rhs)), neg);
          end
        endcase
        if (st == ST_OK) begin
          depth--;
          opnds[depth-1] = acc;
        end
      end
    end else begin
      st = ST_BADTOK;
    end
    if (st != ST_OK) begin
      depth = 0;
      skipping = !t.eoe;
      emits = 1;
      r.status = st;
      return;
    end
    if (t.eoe) begin
      emits = 1;
      if (depth == 1) r.value = opnds[0][VW-1:0];
      else r.status = ST_LEFTOVER;
      depth = 0;
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin : monitor
    result_t want;
    result_t r;
    bit      emits;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        res_taken = 1;
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing pending", longint'(out_ch.status), -1);
        end else begin
          want = results_due.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", longint'(out_ch.status), longint'(want.status));
          if (out_ch.value !== want.value)
            report_mismatch("value", longint'($signed(out_ch.value)),
                            longint'($signed(want.value)));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        tok_taken = 1;
        eval_token(token_t'{in_ch.cmd, in_ch.digit, in_ch.end_of_expr}, emits, r);
        if (emits) results_due.push_back(r);
      end
    end
  end

  // drive both channels at the falling edge
  always @(negedge clk) begin : driver
    token_t t;
    bit     took;
    if (rst_n) begin
      took = tok_taken;
      if (tok_taken) begin
        tok_taken = 0;
        tok_gap = steady ? 0 : $urandom_range(0, 4);
        taken_cnt++;
        // alternate between random gaps and back-to-back stretches
        if (taken_cnt % 64 == 0) steady = !steady;
      end
      if (!(in_ch.valid && !took)) begin
        if (tok_gap > 0) begin
          tok_gap--;
          in_ch.valid <= 1'b0;
        end else if (token_q.size() > 0) begin
          t = token_q.pop_front();
          in_ch.cmd <= t.cmd;
          in_ch.digit <= t.digit;
          in_ch.end_of_expr <= t.eoe;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (res_taken) begin
        res_taken = 0;
        res_stall = steady ? 0 : $urandom_range(0, 4);
      end
      if (res_stall > 0) begin
        res_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_tok(input logic [CMD_W-1:0] c, input logic [DIGIT_W-1:0] d,
                         input bit eoe = 0);
    token_q.push_back(token_t'{c, d, eoe});
  endtask

  task automatic close_expr();
    token_q[$].eoe = 1'b1;
  endtask

  function automatic logic [CMD_W-1:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return CMD_ADD;
      1:       return CMD_SUB;
      2, 3:    return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  // random expression; extra digits leave a leftover, extra operators underflow
  task automatic gen_expr(input int n_ops, input int extra_digits, input int extra_ops);
    int digits_left, ops_left, level;
    digits_left = n_ops + 1 + extra_digits;
    ops_left = n_ops + extra_ops;
    level = 0;
    while (digits_left > 0 || ops_left > 0) begin
      if (ops_left > 0 && (digits_left == 0 || (level >= 2 && $urandom_range(0, 1)))) begin
        add_tok(pick_op(), DIGIT_W'($urandom_range(0, 15)));
        ops_left--;
        level--;
      end else begin
        add_tok(CMD_DIGIT, DIGIT_W'($urandom_range(0, 9)));
        digits_left--;
        level++;
      end
    end
    close_expr();
  endtask

  // repeated multiplies that can push the value into saturation
  task automatic gen_mul_chain();
    if ($urandom_range(0, 1)) begin
      add_tok(CMD_DIGIT, 0);
      add_tok(CMD_DIGIT, 9);
      add_tok(CMD_SUB, 0);
    end else begin
      add_tok(CMD_DIGIT, 9);
    end
    add_tok(CMD_DIGIT, 9);
    add_tok(CMD_MUL, 0);
    repeat ($urandom_range(5, 11)) begin
      add_tok(CMD_DIGIT, DIGIT_W'($urandom_range(5, 9)));
      add_tok(CMD_MUL, 0);
    end
    case ($urandom_range(0, 3))
      0: begin
        add_tok(CMD_DIGIT, 9);
        add_tok(CMD_ADD, 0);
      end
      1: begin
        add_tok(CMD_DIGIT, 9);
        add_tok(CMD_SUB, 0);
      end
      2: begin
        // divide by one ninth
        add_tok(CMD_DIGIT, 1);
        add_tok(CMD_DIGIT, 9);
        add_tok(CMD_DIV, 0);
        add_tok(CMD_DIV, 0);
      end
      default: ;
    endcase
    close_expr();
  endtask

  // fill the stack to within three of its depth or past it, then fold it back down
  task automatic gen_deep_stack();
    int n;
    n = $urandom_range(DEPTH - 3, DEPTH + 1);
    repeat (n) add_tok(CMD_DIGIT, DIGIT_W'($urandom_range(1, 9)));
    if (n <= DEPTH) repeat ($urandom_range(n - 2, n - 1)) add_tok(pick_op(), 0);
    else repeat ($urandom_range(1, 3)) add_tok(pick_op(), 0);
    close_expr();
  endtask

  task automatic gen_broken();
    int first, idx;
    first = token_q.size();
    case ($urandom_range(0, 2))
      0: gen_expr($urandom_range(0, 4), 1, 0);
      1: gen_expr($urandom_range(0, 4), 0, $urandom_range(1, 2));
      default: begin
        gen_expr($urandom_range(1, 5), 0, 0);
        idx = $urandom_range(first, token_q.size() - 1);
        if ($urandom_range(0, 1)) begin
          token_q[idx].cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        end else begin
          token_q[idx].cmd = CMD_DIGIT;
          token_q[idx].digit = DIGIT_W'($urandom_range(DIGIT_MAX + 1, 15));
        end
      end
    endcase
  endtask

  initial begin : stimulus
    int pick;
    // short directed expressions
    add_tok(CMD_DIGIT, 3); add_tok(CMD_DIGIT, 4); add_tok(CMD_ADD, 0, 1);
    add_tok(CMD_DIGIT, 8); add_tok(CMD_DIGIT, 0); add_tok(CMD_DIGIT, 9);
    add_tok(CMD_SUB, 0); add_tok(CMD_MUL, 0, 1);
    add_tok(CMD_DIGIT, 1); add_tok(CMD_DIGIT, 3); add_tok(CMD_DIV, 0, 1);
    add_tok(CMD_DIGIT, 0); add_tok(CMD_DIGIT, 1); add_tok(CMD_SUB, 0);
    add_tok(CMD_DIGIT, 3); add_tok(CMD_DIV, 0, 1);
    add_tok(CMD_DIGIT, 15, 1);
    add_tok(CMD_DIGIT, 1); add_tok(CMD_RSVD_LAST, 0);
    add_tok(CMD_DIGIT, 2); add_tok(CMD_ADD, 0, 1);
    add_tok(CMD_DIGIT, 5); add_tok(CMD_ADD, 0, 1);
    add_tok(CMD_DIGIT, 5); add_tok(CMD_DIGIT, 0); add_tok(CMD_DIV, 0, 1);
    add_tok(CMD_DIGIT, 3); add_tok(CMD_DIGIT, 4, 1);

    while (token_q.size() < 440) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gen_expr($urandom_range(0, 6), 0, 0);
      else if (pick < 65) gen_mul_chain();
      else if (pick < 73) gen_deep_stack();
      else if (pick < 83) begin
        repeat ($urandom_range(1, 6))
          add_tok(CMD_W'($urandom_range(CMD_DIGIT, CMD_RSVD_LAST)),
                  DIGIT_W'($urandom_range(0, 15)),
                  $urandom_range(0, 3) == 0);
        close_expr();
      end else gen_broken();
    end

    @(posedge clk);
    while (!rst_n || token_q.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/rpn_pkg.sv
rtl/rpn_in_if.sv
rtl/rpn_out_if.sv
rtl/rpn_stack_evaluator_core.sv
verif/tb_top.sv
